// ===== design/rsfp_pkg.sv =====
// Package with the types, codes and constants of the range sensor frame parser.
package rsfp_pkg;

  localparam logic [7:0]  HEADER_BYTE       = 8'h5C;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam logic [15:0] MAX_RANGE_RESET   = 16'd12000;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd2000;
  localparam int          CFG_ADDR_W        = 1;
  localparam int          CFG_DATA_W        = 16;
  localparam int          OUT_TDATA_W       = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_RANGE = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic {
    EVT_FRAME   = 1'b0,
    EVT_OFFLINE = 1'b1
  } evt_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_CHECKSUM = 3'd1,
    ERR_INVALID  = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_OFFLINE  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef struct packed {
    logic        sensor_online;
    err_t        error_code;
    logic        distance_valid;
    logic [15:0] distance_mm;
    evt_t        event_kind;
  } result_t;

endpackage

// ===== design/rsfp_core.sv =====
// Frame parser state machine, configuration registers and offline timer.
module rsfp_core
  import rsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_accept,
  input  cmd_t                  item_cmd,
  input  logic [7:0]            item_byte,
  output logic                  res_valid,
  output result_t               res_data
);

  logic [15:0] max_range_r;
  logic [15:0] timeout_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        online_r, online_nxt;
  logic [15:0] count_r, count_nxt;

  logic [15:0] count_inc;
  logic        timeout_hit;
  logic [7:0]  expect_sum;
  logic [15:0] frame_dist;
  err_t        frame_err;

  assign count_inc   = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
  assign timeout_hit = online_r && (count_inc > timeout_r);
  assign expect_sum  = ~(low_r + high_r);
  assign frame_dist  = {high_r, low_r};

  always_comb begin
    if (expect_sum != item_byte) begin
      frame_err = ERR_CHECKSUM;
    end else if (frame_dist == 16'h0000 || frame_dist == 16'hFFFF) begin
      frame_err = ERR_INVALID;
    end else if (frame_dist > max_range_r) begin
      frame_err = ERR_RANGE;
    end else begin
      frame_err = ERR_OK;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    online_nxt = online_r;
    count_nxt  = count_r;
    if (item_accept) begin
      if (item_cmd == CMD_TICK) begin
        count_nxt = count_inc;
        if (timeout_hit) begin
          online_nxt = 1'b0;
        end
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (item_byte == HEADER_BYTE) begin
              phase_nxt = PH_LOW;
            end
          end
          PH_LOW: begin
            low_nxt   = item_byte;
            phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            high_nxt  = item_byte;
            phase_nxt = PH_CHECK;
          end
          PH_CHECK: begin
            phase_nxt = PH_HUNT;
            if (frame_err == ERR_OK) begin
              online_nxt = 1'b1;
              count_nxt  = 16'd0;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result outputs.
  always_comb begin
    res_valid                = 1'b0;
    res_data.event_kind      = EVT_FRAME;
    res_data.distance_mm     = frame_dist;
    res_data.distance_valid  = (frame_err == ERR_OK);
    res_data.error_code      = frame_err;
    res_data.sensor_online   = online_nxt;
    if (item_cmd == CMD_TICK) begin
      res_valid               = item_accept && timeout_hit;
      res_data.event_kind     = EVT_OFFLINE;
      res_data.distance_mm    = 16'd0;
      res_data.distance_valid = 1'b0;
      res_data.error_code     = ERR_OFFLINE;
    end else begin
      res_valid = item_accept && (phase_r == PH_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r <= MAX_RANGE_RESET;
      timeout_r   <= TIMEOUT_RESET;
      phase_r     <= PH_HUNT;
      low_r       <= 8'd0;
      high_r      <= 8'd0;
      online_r    <= 1'b0;
      count_r     <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_MAX_RANGE: max_range_r <= cfg_wdata;
          CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      online_r <= online_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/rsfp_out_buf.sv =====
// Output register with a skid stage for the parser results.
module rsfp_out_buf
  import rsfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    out_free;

  assign space     = ~skid_valid_r;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end
    if (!out_free && res_valid) begin
      skid_data_r <= res_data;
    end
  end

endmodule

// ===== design/range_sensor_frame_parser_top.sv =====
// Top level of the range sensor frame parser.
// The block takes one item per cycle while in_tready is high: a received byte
// or a millisecond tick, selected by in_tuser. A frame is the header byte 0x5C,
// the distance low byte, the distance high byte and a check byte; the check
// byte yields one result with the distance and an error code, and a tick that
// times out an online sensor yields an offline result. Each item is handled in
// the cycle it is accepted, and its result is registered in the output or skid
// register. A two-entry output buffer lets input continue while a result waits,
// so the input stalls only when two results are held back by out_tready.
module range_sensor_frame_parser_top
  import rsfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // rx_byte
  input  logic                   in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // distance_mm, distance_valid, error_code, sensor_online, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser   // event_kind
);

  logic    item_accept;
  logic    res_valid;
  result_t res_data;
  logic    space;
  result_t out_data;

  assign in_tready   = space;
  assign item_accept = in_tvalid & space;

  rsfp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .item_accept (item_accept),
    .item_cmd    (cmd_t'(in_tuser)),
    .item_byte   (in_tdata),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  rsfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tuser = out_data.event_kind;
  assign out_tdata = {3'b000, out_data.sensor_online, out_data.error_code,
                      out_data.distance_valid, out_data.distance_mm};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the range sensor frame parser top level.
`timescale 1ns / 1ps

module tb_top;
  import rsfp_pkg::*;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx;
  } rx_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  range_sensor_frame_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rx_item_t    rx_feed[$];
  result_t     expected_reports[$];
  bit          offer_live = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  int          reports_seen = 0;
  int          code_tally[5] = '{default: 0};
  int          reg_writes = 0;

  // Shadow copy of the parser state and its two registers.
  logic [15:0] max_range_cfg;
  logic [15:0] timeout_cfg;
  phase_t      hunt_phase;
  logic [7:0]  dist_lo;
  logic [7:0]  dist_hi;
  logic        online;
  logic [15:0] ms_count;

  task automatic parse_rx_item(input cmd_t c, input logic [7:0] b);
    result_t    r;
    logic [7:0] chk;
    logic [15:0] frame_mm;
    err_t       e;
    if (c == CMD_TICK) begin
      if (ms_count != COUNT_MAX) ms_count++;
      if (online && ms_count > timeout_cfg) begin
        online = 1'b0;
        r.event_kind = EVT_OFFLINE;
        r.distance_mm = 16'h0000;
        r.distance_valid = 1'b0;
        r.error_code = ERR_OFFLINE;
        r.sensor_online = 1'b0;
        expected_reports.push_back(r);
      end
    end else begin
      case (hunt_phase)
        PH_HUNT: begin
          if (b == HEADER_BYTE) hunt_phase = PH_LOW;
        end
        PH_LOW: begin
          dist_lo = b;
          hunt_phase = PH_HIGH;
        end
        PH_HIGH: begin
          dist_hi = b;
          hunt_phase = PH_CHECK;
        end
        default: begin
          hunt_phase = PH_HUNT;
          chk = dist_lo + dist_hi;
          chk = ~chk;
          frame_mm = {dist_hi, dist_lo};
          if (chk != b) e = ERR_CHECKSUM;
          else if (frame_mm == 16'h0000 || frame_mm == 16'hFFFF) e = ERR_INVALID;
          else if (frame_mm > max_range_cfg) e = ERR_RANGE;
          else e = ERR_OK;
          if (e == ERR_OK) begin
            online = 1'b1;
            ms_count = 16'h0000;
          end
          r.event_kind = EVT_FRAME;
          r.distance_mm = frame_mm;
          r.distance_valid = (e == ERR_OK);
          r.error_code = e;
          r.sensor_online = online;
          expected_reports.push_back(r);
        end
      endcase
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  task automatic check_report();
    result_t want;
    result_t got;
    got = result_t'({out_tdata[20], out_tdata[19:17], out_tdata[16], out_tdata[15:0],
                     out_tuser});
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing expected, tdata %h tuser %b",
                 $realtime, out_tdata, out_tuser);
    end else begin
      want = expected_reports.pop_front();
      reports_seen++;
      code_tally[want.error_code]++;
      if (got.event_kind !== want.event_kind)
        note_mismatch("event_kind", want.event_kind, got.event_kind);
      if (got.distance_mm !== want.distance_mm)
        note_mismatch("distance_mm", want.distance_mm, got.distance_mm);
      if (got.distance_valid !== want.distance_valid)
        note_mismatch("distance_valid", want.distance_valid, got.distance_valid);
      if (got.error_code !== want.error_code)
        note_mismatch("error_code", want.error_code, got.error_code);
      if (got.sensor_online !== want.sensor_online)
        note_mismatch("sensor_online", want.sensor_online, got.sensor_online);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) begin
        parse_rx_item(cmd_t'(in_tuser), in_tdata);
        void'(rx_feed.pop_front());
        offer_live = 1'b0;
        items_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (!offer_live) begin
      if (rst_n && rx_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser <= rx_feed[0].cmd;
        in_tdata <= rx_feed[0].rx;
        offer_live = 1'b1;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_feed.push_back('{cmd: CMD_BYTE, rx: b});
    items_queued++;
  endtask

  task automatic push_tick();
    rx_feed.push_back('{cmd: CMD_TICK, rx: 8'($urandom)});
    items_queued++;
  endtask

  task automatic push_frame(input logic [15:0] d, input bit chk_ok, input int tick_pct);
    logic [7:0] chk;
    chk = d[7:0] + d[15:8];
    chk = ~chk;
    if (!chk_ok) chk = chk ^ 8'($urandom_range(1, 255));
    push_byte(HEADER_BYTE);
    if ($urandom_range(99) < tick_pct) push_tick();
    push_byte(d[7:0]);
    if ($urandom_range(99) < tick_pct) push_tick();
    push_byte(d[15:8]);
    if ($urandom_range(99) < tick_pct) push_tick();
    push_byte(chk);
  endtask

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return max_range_cfg;
      3: return max_range_cfg + 16'd1;
      4: return 16'($urandom);
      5: return max_range_cfg - 16'd1;
      default: begin
        if (max_range_cfg == 16'h0000) return 16'($urandom);
        return 16'($urandom_range(1, max_range_cfg));
      end
    endcase
  endfunction

  task automatic fill_random(input int n);
    int target;
    int sel;
    int k;
    target = items_queued + n;
    while (items_queued < target) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        push_frame(pick_distance(), $urandom_range(99) < 85, 8);
      end else if (sel < 80) begin
        k = ($urandom_range(3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
        repeat (k) push_tick();
      end else if (sel < 90) begin
        push_byte(8'($urandom));
      end else begin
        push_byte(HEADER_BYTE);
        k = $urandom_range(0, 2);
        repeat (k) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_feed.size() > 0 || offer_live || expected_reports.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_MAX_RANGE) max_range_cfg = val;
    else timeout_cfg = val;
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] max_mm, input logic [15:0] tmo,
                           input int send_pct, input int recv_pct, input int n);
    wait_drained();
    write_reg(CFG_MAX_RANGE, max_mm);
    write_reg(CFG_TIMEOUT, tmo);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    fill_random(n);
  endtask

  initial begin
    max_range_cfg = MAX_RANGE_RESET;
    timeout_cfg = TIMEOUT_RESET;
    hunt_phase = PH_HUNT;
    dist_lo = 8'h00;
    dist_hi = 8'h00;
    online = 1'b0;
    ms_count = 16'h0000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_tick();
    push_frame(16'd1, 1'b1, 0);
    push_frame(16'h1234, 1'b0, 0);
    push_frame(16'h0000, 1'b1, 0);
    push_frame(16'hFFFF, 1'b1, 0);
    push_frame(16'd12001, 1'b1, 0);
    push_frame(16'd12000, 1'b1, 0);

    // A zero timeout drops an online sensor on the first tick.
    wait_drained();
    write_reg(CFG_TIMEOUT, 16'd0);
    push_tick();
    push_frame(16'd500, 1'b1, 0);
    push_tick();
    push_tick();

    run_phase(16'd65535, 16'd5, 0, 0, 220);
    run_phase(16'd0, 16'd1, 64, 0, 220);
    run_phase(16'd1000, 16'd0, 0, 64, 220);
    run_phase(16'd40000, 16'd65535, 31, 31, 220);

    // A tick count equal to the timeout keeps the sensor online, one more drops it.
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_TIMEOUT, 16'd3);
    push_frame(16'd100, 1'b1, 0);
    repeat (4) push_tick();

    // The receiver holds off while frames keep coming, so the input backs up.
    wait_drained();
    write_reg(CFG_MAX_RANGE, 16'd12000);
    write_reg(CFG_TIMEOUT, 16'd20);
    hold_left = 400;
    fill_random(220);

    run_phase(16'd300, 16'd3, 64, 0, 220);
    run_phase(16'd65534, 16'd10, 0, 64, 220);
    run_phase(16'd5000, 16'd2, 31, 31, 220);

    while (rx_feed.size() > 0 || offer_live || expected_reports.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results from %0d items over %0d register writes.",
             reports_seen, items_taken, reg_writes);
    $display("Codes seen: ok %0d, checksum %0d, invalid %0d, range %0d, offline %0d.",
             code_tally[0], code_tally[1], code_tally[2], code_tally[3], code_tally[4]);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d items pending.", rx_feed.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
